FILE: hw/rtl/cyrillic_codepage_to_utf8_unit_defines.svh
// assertion helpers shared by the checker
`ifndef CYRILLIC_CODEPAGE_TO_UTF8_UNIT_DEFINES_SVH
`define CYRILLIC_CODEPAGE_TO_UTF8_UNIT_DEFINES_SVH

// same-cycle implication, quiet while reset is high
`define C2U_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("c2u assertion failed");

// next-cycle implication, quiet while reset is high
`define C2U_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("c2u assertion failed");

`endif

FILE: hw/rtl/c2u_pkg.sv
package c2u_pkg;

   typedef enum logic [1:0] {
      CP_1251   = 2'd0,
      CP_866    = 2'd1,
      CP_KOI8R  = 2'd2,
      CP_UNUSED = 2'd3
   } code_page_type;

   localparam logic [7:0] LeadLo    = 8'hD0;
   localparam logic [7:0] LeadHi    = 8'hD1;
   localparam logic [7:0] YoLow     = 8'h81;
   localparam logic [7:0] YoSmall   = 8'h91;
   localparam logic [8:0] KoiBase   = 9'h090;
   localparam logic [1:0] CountOne  = 2'd1;
   localparam logic [1:0] CountTwo  = 2'd2;

   typedef struct packed {
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic [1:0] byte_count;
   } result_type;

   // koi8-r letters 0xc0..0xff: utf-8 pair minus 0xd090, low byte only
   function automatic logic [7:0] koi_offset(input logic [5:0] idx);
      logic [7:0] v;
      case (idx)
         6'd0:  v = 8'hfe;  6'd1:  v = 8'h20;  6'd2:  v = 8'h21;  6'd3:  v = 8'hf6;
         6'd4:  v = 8'h24;  6'd5:  v = 8'h25;  6'd6:  v = 8'hf4;  6'd7:  v = 8'h23;
         6'd8:  v = 8'hf5;  6'd9:  v = 8'h28;  6'd10: v = 8'h29;  6'd11: v = 8'h2a;
         6'd12: v = 8'h2b;  6'd13: v = 8'h2c;  6'd14: v = 8'h2d;  6'd15: v = 8'h2e;
         6'd16: v = 8'h2f;  6'd17: v = 8'hff;  6'd18: v = 8'hf0;  6'd19: v = 8'hf1;
         6'd20: v = 8'hf2;  6'd21: v = 8'hf3;  6'd22: v = 8'h26;  6'd23: v = 8'h22;
         6'd24: v = 8'hfc;  6'd25: v = 8'hfb;  6'd26: v = 8'h27;  6'd27: v = 8'hf8;
         6'd28: v = 8'hfd;  6'd29: v = 8'hf9;  6'd30: v = 8'hf7;  6'd31: v = 8'hfa;
         6'd32: v = 8'h1e;  6'd33: v = 8'h00;  6'd34: v = 8'h01;  6'd35: v = 8'h16;
         6'd36: v = 8'h04;  6'd37: v = 8'h05;  6'd38: v = 8'h14;  6'd39: v = 8'h03;
         6'd40: v = 8'h15;  6'd41: v = 8'h08;  6'd42: v = 8'h09;  6'd43: v = 8'h0a;
         6'd44: v = 8'h0b;  6'd45: v = 8'h0c;  6'd46: v = 8'h0d;  6'd47: v = 8'h0e;
         6'd48: v = 8'h0f;  6'd49: v = 8'h1f;  6'd50: v = 8'h10;  6'd51: v = 8'h11;
         6'd52: v = 8'h12;  6'd53: v = 8'h13;  6'd54: v = 8'h06;  6'd55: v = 8'h02;
         6'd56: v = 8'h1c;  6'd57: v = 8'h1b;  6'd58: v = 8'h07;  6'd59: v = 8'h18;
         6'd60: v = 8'h1d;  6'd61: v = 8'h19;  6'd62: v = 8'h17;  6'd63: v = 8'h1a;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

endpackage

FILE: hw/rtl/c2u_req_if.sv
interface c2u_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

FILE: hw/rtl/c2u_rsp_if.sv
interface c2u_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] first_byte;
   logic [7:0] second_byte;
   logic [1:0] byte_count;

   modport source (output valid, output first_byte, output second_byte,
                   output byte_count, input ready);
   modport sink (input valid, input first_byte, input second_byte,
                 input byte_count, output ready);
endinterface

FILE: hw/rtl/cyrillic_codepage_to_utf8_unit.sv
// Cyrillic code page to UTF-8 transcoder.
// req_ch carries one source byte per item (valid/ready, accepted when both
// are high). rsp_ch returns one item per input: first_byte, second_byte and
// byte_count (1 or 2); second_byte is zero when byte_count is 1.
// csr_wr_en/csr_wr_data write the code page register: 0 cp1251, 1 cp866,
// 2 KOI8-R, 3 passes every byte through raw. Write it only while no item
// is in flight.
// An accepted item waits in the input register, moves into the result
// register once that is empty or being read, and is offered on rsp_ch from
// there. Throughput: one item per cycle while rsp_ch.ready stays high; the
// translation is a compare, an add and a 64-entry table lookup between the
// two registers.
// Reset (synchronous, active high) empties both stages and sets the code
// page to cp1251.
// When the receiver holds rsp_ch.ready low the result register keeps its
// item, the input register still takes one more item, and only then does
// req_ch.ready drop; no item is lost or repeated.
module cyrillic_codepage_to_utf8_unit (
   input logic              clock,
   input logic              reset,
   c2u_req_if.sink          req_ch,
   c2u_rsp_if.source        rsp_ch,
   input logic              csr_wr_en,
   input logic [1:0]        csr_wr_data
);

   c2u_pkg::code_page_type code_page_ff;
   logic                   s1_valid_ff, s1_valid_in;
   logic [7:0]             s1_byte_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   c2u_pkg::result_type    rsp_data_ff;
   c2u_pkg::result_type    map_result;
   logic                   s2_load;
   logic                   req_take;

   c2u_map u_map (
      .code_page (code_page_ff),
      .in_byte   (s1_byte_ff),
      .result    (map_result)
   );

   assign s2_load      = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s2_load;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_comb begin
      s1_valid_in  = req_take ? 1'b1 : (s2_load ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s2_load ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_page_ff <= c2u_pkg::CP_1251;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            code_page_ff <= c2u_pkg::code_page_type'(csr_wr_data);
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_ch.in_byte;
      end
      if (s2_load) begin
         rsp_data_ff <= map_result;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.first_byte  = rsp_data_ff.first_byte;
   assign rsp_ch.second_byte = rsp_data_ff.second_byte;
   assign rsp_ch.byte_count  = rsp_data_ff.byte_count;

endmodule

FILE: hw/rtl/c2u_map.sv
module c2u_map (
   input  c2u_pkg::code_page_type code_page,
   input  logic [7:0]             in_byte,
   output c2u_pkg::result_type    result
);

   logic [8:0] koi_sum;

   assign koi_sum = {1'b0, c2u_pkg::koi_offset(in_byte[5:0])} + c2u_pkg::KoiBase;

   always_comb begin
      // raw single byte unless a letter rule below applies
      result.first_byte  = in_byte;
      result.second_byte = 8'h00;
      result.byte_count  = c2u_pkg::CountOne;
      if (in_byte[7]) begin
         case (code_page)
            c2u_pkg::CP_1251: begin
               result.byte_count = c2u_pkg::CountTwo;
               if (in_byte == 8'hA8) begin
                  result.first_byte  = c2u_pkg::LeadLo;
                  result.second_byte = c2u_pkg::YoLow;
               end else if (in_byte == 8'hB8) begin
                  result.first_byte  = c2u_pkg::LeadHi;
                  result.second_byte = c2u_pkg::YoSmall;
               end else if (in_byte <= 8'hEF) begin
                  result.first_byte  = c2u_pkg::LeadLo;
                  result.second_byte = in_byte + 8'hD0;
               end else begin
                  result.first_byte  = c2u_pkg::LeadHi;
                  result.second_byte = in_byte - 8'h70;
               end
            end
            c2u_pkg::CP_866: begin
               if (in_byte == 8'hF0) begin
                  result.first_byte  = c2u_pkg::LeadLo;
                  result.second_byte = c2u_pkg::YoLow;
                  result.byte_count  = c2u_pkg::CountTwo;
               end else if (in_byte == 8'hF1) begin
                  result.first_byte  = c2u_pkg::LeadHi;
                  result.second_byte = c2u_pkg::YoSmall;
                  result.byte_count  = c2u_pkg::CountTwo;
               end else if (in_byte <= 8'hAF) begin
                  result.first_byte  = c2u_pkg::LeadLo;
                  result.second_byte = in_byte + 8'h10;
                  result.byte_count  = c2u_pkg::CountTwo;
               end else if (in_byte[7:4] == 4'hE) begin
                  result.first_byte  = c2u_pkg::LeadHi;
                  result.second_byte = in_byte - 8'h60;
                  result.byte_count  = c2u_pkg::CountTwo;
               end
            end
            c2u_pkg::CP_KOI8R: begin
               if (in_byte == 8'hB3) begin
                  result.first_byte  = c2u_pkg::LeadLo;
                  result.second_byte = c2u_pkg::YoLow;
                  result.byte_count  = c2u_pkg::CountTwo;
               end else if (in_byte == 8'hA3) begin
                  result.first_byte  = c2u_pkg::LeadHi;
                  result.second_byte = c2u_pkg::YoSmall;
                  result.byte_count  = c2u_pkg::CountTwo;
               end else if (in_byte[6]) begin
                  // table letters, carry out of the low byte picks the lead
                  result.first_byte  = koi_sum[8] ? c2u_pkg::LeadHi : c2u_pkg::LeadLo;
                  result.second_byte = koi_sum[7:0];
                  result.byte_count  = c2u_pkg::CountTwo;
               end
            end
            default: begin
               result.first_byte = in_byte;
            end
         endcase
      end
   end

endmodule

FILE: hw/rtl/c2u_checker.sv
`include "cyrillic_codepage_to_utf8_unit_defines.svh"

module c2u_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_first_byte,
   input logic [7:0] rsp_second_byte,
   input logic [1:0] rsp_byte_count
);

   `C2U_ASSERT_SAME(a_count_legal, clock, reset, rsp_valid,
      rsp_byte_count == c2u_pkg::CountOne || rsp_byte_count == c2u_pkg::CountTwo)

   `C2U_ASSERT_SAME(a_single_zero, clock, reset,
      rsp_valid && rsp_byte_count == c2u_pkg::CountOne, rsp_second_byte == 8'h00)

   `C2U_ASSERT_SAME(a_pair_lead, clock, reset,
      rsp_valid && rsp_byte_count == c2u_pkg::CountTwo,
      rsp_first_byte == c2u_pkg::LeadLo || rsp_first_byte == c2u_pkg::LeadHi)

   `C2U_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_first_byte) && $stable(rsp_second_byte)
      && $stable(rsp_byte_count))

endmodule

bind cyrillic_codepage_to_utf8_unit c2u_checker u_c2u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_first_byte  (rsp_ch.first_byte),
   .rsp_second_byte (rsp_ch.second_byte),
   .rsp_byte_count  (rsp_ch.byte_count)
);
